FILE: hdl/dtfg_pkg.sv
// dtfg_pkg: beat types, pipeline constants and the tonic table of the
// diatonic triad frequency generator; no dependencies
package dtfg_pkg;

  localparam int FreqW   = 14;
  localparam int TonicW  = 13;
  localparam int CntW    = 7;
  localparam int RootNumW = 16;
  localparam int NumStg  = 7;

  // reciprocal multipliers for the exact divisions by three and five
  localparam logic [15:0] Div3Mul = 16'd43691;
  localparam int          Div3Sh  = 17;
  localparam logic [15:0] Div5Mul = 16'd52429;
  localparam int          Div5Sh  = 18;
  localparam logic [7:0]  Cnt3Mul = 8'd171;
  localparam int          Cnt3Sh  = 9;

  localparam logic [2:0] DegI    = 3'd0;
  localparam logic [2:0] DegII   = 3'd1;
  localparam logic [2:0] DegIII  = 3'd2;
  localparam logic [2:0] DegIV   = 3'd3;
  localparam logic [2:0] DegV    = 3'd4;
  localparam logic [2:0] DegVI   = 3'd5;
  localparam logic [2:0] DegVII  = 3'd6;
  localparam logic [2:0] DegNone = 3'd7;

  typedef struct packed {
    logic [3:0] key;
    logic [2:0] chord;
    logic       swap_quality;
    logic [7:0] inversion;
  } in_beat_t;

  typedef struct packed {
    logic [FreqW-1:0] low_freq;
    logic [FreqW-1:0] mid_freq;
    logic [FreqW-1:0] high_freq;
  } out_beat_t;

  // keys twelve to fifteen wrap onto the first four entries
  function automatic logic [TonicW-1:0] tonic_lookup(input logic [3:0] key);
    logic [TonicW-1:0] t;
    case (key)
      4'd0, 4'd12: t = 13'd3520;
      4'd1, 4'd13: t = 13'd3729;
      4'd2, 4'd14: t = 13'd3951;
      4'd3, 4'd15: t = 13'd4186;
      4'd4:        t = 13'd4435;
      4'd5:        t = 13'd4699;
      4'd6:        t = 13'd4978;
      4'd7:        t = 13'd5274;
      4'd8:        t = 13'd5588;
      4'd9:        t = 13'd5920;
      4'd10:       t = 13'd6272;
      4'd11:       t = 13'd6645;
      default:     t = 13'd3520;
    endcase
    return t;
  endfunction

endpackage

FILE: hdl/diatonic_triad_frequency_generator_unit.sv
// diatonic_triad_frequency_generator_unit: seven stage pipeline from key and
// degree to the three sorted, octave dropped chord tones; uses dtfg_pkg
//
// usage
//   in channel : in_valid_i / in_ready_o, beat in_i (key, chord, swap_quality,
//                inversion)
//   out channel: out_valid_o / out_ready_i, beat out_o (low_freq, mid_freq,
//                high_freq), one result beat for every input beat, in order
//   throughput : one beat per cycle unless stalled; seven register stages,
//                each with its own valid bit, let a new beat enter every cycle
//   stages     : tonic lookup and root numerator, division by three, third
//                and fifth products, division by five, octave fold, sort,
//                inversion shifts into the output register
//   reset      : rst_ni clears every stage valid bit; the pipeline is empty
//                and in_ready_o is high after reset
//   stall      : with out_ready_i low, beats close up behind the output
//                register; in_ready_o falls only once every stage holds a beat
//   no internal state carries between beats
module diatonic_triad_frequency_generator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dtfg_pkg::in_beat_t in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dtfg_pkg::out_beat_t out_o
);
  import dtfg_pkg::*;

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] rdy;

  // stage 0 combinational
  logic [TonicW-1:0]   s0_tonic;
  logic [16:0]         s0_t17;
  logic [RootNumW-1:0] s0_num;
  logic                s0_div3, s0_minor, s0_dim;
  logic [8:0]          s0_x_hi, s0_x_mid, s0_x_lo;
  logic [CntW-1:0]     s0_cnt_hi, s0_cnt_mid, s0_cnt_lo;

  // stage registers
  logic [TonicW-1:0]   s1_tonic_q;
  logic [RootNumW-1:0] s1_num_q;
  logic                s1_div3_q, s1_minor_q, s1_dim_q;
  logic [CntW-1:0]     s1_cnt_hi_q, s1_cnt_mid_q, s1_cnt_lo_q;

  logic [TonicW-1:0]   s2_tonic_q;
  logic [FreqW-1:0]    s2_root_q;
  logic                s2_minor_q, s2_dim_q;
  logic [CntW-1:0]     s2_cnt_hi_q, s2_cnt_mid_q, s2_cnt_lo_q;

  logic [TonicW-1:0]   s3_tonic_q;
  logic [FreqW-1:0]    s3_root_q;
  logic [16:0]         s3_tn_q;
  logic [19:0]         s3_fn_q;
  logic                s3_minor_q, s3_dim_q;
  logic [CntW-1:0]     s3_cnt_hi_q, s3_cnt_mid_q, s3_cnt_lo_q;

  logic [17:0]         s4_thr_q;
  logic [FreqW-1:0]    s4_root_q;
  logic [14:0]         s4_third_q, s4_fifth_q;
  logic [CntW-1:0]     s4_cnt_hi_q, s4_cnt_mid_q, s4_cnt_lo_q;

  logic [FreqW-1:0]    s5_root_q, s5_third_q, s5_fifth_q;
  logic [CntW-1:0]     s5_cnt_hi_q, s5_cnt_mid_q, s5_cnt_lo_q;

  logic [FreqW-1:0]    s6_lo_q, s6_mid_q, s6_hi_q;
  logic [CntW-1:0]     s6_cnt_hi_q, s6_cnt_mid_q, s6_cnt_lo_q;

  out_beat_t           s7_out_q;

  logic [FreqW-1:0]    s2_root_d;
  logic [14:0]         s4_third_d, s4_fifth_d;
  logic [FreqW-1:0]    s6_lo_d, s6_mid_d, s6_hi_d;

  function automatic logic [FreqW-1:0] fold(input logic [14:0] tone,
                                            input logic [17:0] thr);
    logic [18:0] scaled;
    scaled = 19'(tone) * 19'd20;
    if (scaled >= 19'(thr)) begin
      return FreqW'(tone >> 1);
    end
    return FreqW'(tone);
  endfunction

  // ready chain, from the output register back to the input
  always_comb begin
    rdy[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NumStg-1];
  assign out_o       = s7_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 0: tonic, root numerator, third quality, drop counts
  always_comb begin
    s0_tonic = tonic_lookup(in_i.key);
    s0_t17   = 17'(s0_tonic);
    s0_div3  = 1'b0;
    s0_minor = 1'b0;
    s0_dim   = 1'b0;
    case (in_i.chord)
      DegI:   s0_num = RootNumW'(s0_t17);
      DegII: begin
        s0_num   = RootNumW'((s0_t17 * 17'd9) >> 3);
        s0_minor = 1'b1;
      end
      DegIII: begin
        s0_num   = RootNumW'((s0_t17 * 17'd5) >> 2);
        s0_minor = 1'b1;
      end
      DegIV: begin
        s0_num  = RootNumW'(s0_t17 * 17'd4);
        s0_div3 = 1'b1;
      end
      DegV:   s0_num = RootNumW'((s0_t17 * 17'd3) >> 1);
      DegVI: begin
        s0_num   = RootNumW'(s0_t17 * 17'd5);
        s0_div3  = 1'b1;
        s0_minor = 1'b1;
      end
      DegVII: begin
        s0_num   = RootNumW'((s0_t17 * 17'd15) >> 3);
        s0_minor = 1'b1;
        s0_dim   = 1'b1;
      end
      DegNone: s0_num = '0;
      default: s0_num = '0;
    endcase
    s0_minor = s0_minor ^ in_i.swap_quality;

    s0_x_hi    = 9'(in_i.inversion) + 9'd2;
    s0_x_mid   = 9'(in_i.inversion) + 9'd1;
    s0_x_lo    = 9'(in_i.inversion);
    s0_cnt_hi  = CntW'((16'(s0_x_hi) * 16'(Cnt3Mul)) >> Cnt3Sh);
    s0_cnt_mid = CntW'((16'(s0_x_mid) * 16'(Cnt3Mul)) >> Cnt3Sh);
    s0_cnt_lo  = CntW'((16'(s0_x_lo) * 16'(Cnt3Mul)) >> Cnt3Sh);
  end

  always_comb begin
    if (s1_div3_q) begin
      s2_root_d = FreqW'((32'(s1_num_q) * 32'(Div3Mul)) >> Div3Sh);
    end else begin
      s2_root_d = FreqW'(s1_num_q);
    end
  end

  always_comb begin
    if (s3_minor_q) begin
      s4_third_d = 15'((34'(s3_tn_q) * 34'(Div5Mul)) >> Div5Sh);
    end else begin
      s4_third_d = 15'(s3_tn_q >> 2);
    end
    if (s3_dim_q) begin
      s4_fifth_d = 15'(s3_fn_q >> 5);
    end else begin
      s4_fifth_d = 15'(s3_fn_q >> 1);
    end
  end

  // sort, a tie leaves the fifth in the middle
  always_comb begin
    s6_lo_d = s5_root_q;
    if (s5_third_q < s6_lo_d) s6_lo_d = s5_third_q;
    if (s5_fifth_q < s6_lo_d) s6_lo_d = s5_fifth_q;
    s6_hi_d = s5_root_q;
    if (s5_third_q > s6_hi_d) s6_hi_d = s5_third_q;
    if (s5_fifth_q > s6_hi_d) s6_hi_d = s5_fifth_q;
    if (s5_root_q > s6_lo_d && s5_root_q < s6_hi_d) begin
      s6_mid_d = s5_root_q;
    end else if (s5_third_q > s6_lo_d && s5_third_q < s6_hi_d) begin
      s6_mid_d = s5_third_q;
    end else begin
      s6_mid_d = s5_fifth_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_tonic_q   <= s0_tonic;
      s1_num_q     <= s0_num;
      s1_div3_q    <= s0_div3;
      s1_minor_q   <= s0_minor;
      s1_dim_q     <= s0_dim;
      s1_cnt_hi_q  <= s0_cnt_hi;
      s1_cnt_mid_q <= s0_cnt_mid;
      s1_cnt_lo_q  <= s0_cnt_lo;
    end
    if (rdy[1]) begin
      s2_tonic_q   <= s1_tonic_q;
      s2_root_q    <= s2_root_d;
      s2_minor_q   <= s1_minor_q;
      s2_dim_q     <= s1_dim_q;
      s2_cnt_hi_q  <= s1_cnt_hi_q;
      s2_cnt_mid_q <= s1_cnt_mid_q;
      s2_cnt_lo_q  <= s1_cnt_lo_q;
    end
    if (rdy[2]) begin
      s3_tonic_q   <= s2_tonic_q;
      s3_root_q    <= s2_root_q;
      s3_tn_q      <= s2_minor_q ? 17'(s2_root_q) * 17'd6 : 17'(s2_root_q) * 17'd5;
      s3_fn_q      <= s2_dim_q ? 20'(s2_root_q) * 20'd45 : 20'(s2_root_q) * 20'd3;
      s3_minor_q   <= s2_minor_q;
      s3_dim_q     <= s2_dim_q;
      s3_cnt_hi_q  <= s2_cnt_hi_q;
      s3_cnt_mid_q <= s2_cnt_mid_q;
      s3_cnt_lo_q  <= s2_cnt_lo_q;
    end
    if (rdy[3]) begin
      s4_thr_q     <= 18'(s3_tonic_q) * 18'd39;
      s4_root_q    <= s3_root_q;
      s4_third_q   <= s4_third_d;
      s4_fifth_q   <= s4_fifth_d;
      s4_cnt_hi_q  <= s3_cnt_hi_q;
      s4_cnt_mid_q <= s3_cnt_mid_q;
      s4_cnt_lo_q  <= s3_cnt_lo_q;
    end
    if (rdy[4]) begin
      s5_root_q    <= fold(15'(s4_root_q), s4_thr_q);
      s5_third_q   <= fold(s4_third_q, s4_thr_q);
      s5_fifth_q   <= fold(s4_fifth_q, s4_thr_q);
      s5_cnt_hi_q  <= s4_cnt_hi_q;
      s5_cnt_mid_q <= s4_cnt_mid_q;
      s5_cnt_lo_q  <= s4_cnt_lo_q;
    end
    if (rdy[5]) begin
      s6_lo_q      <= s6_lo_d;
      s6_mid_q     <= s6_mid_d;
      s6_hi_q      <= s6_hi_d;
      s6_cnt_hi_q  <= s5_cnt_hi_q;
      s6_cnt_mid_q <= s5_cnt_mid_q;
      s6_cnt_lo_q  <= s5_cnt_lo_q;
    end
    if (rdy[6]) begin
      s7_out_q.low_freq  <= s6_lo_q >> s6_cnt_lo_q;
      s7_out_q.mid_freq  <= s6_mid_q >> s6_cnt_mid_q;
      s7_out_q.high_freq <= s6_hi_q >> s6_cnt_hi_q;
    end
  end

`ifndef ASSERT_OFF
  a_rdy_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output side is ready");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (s6_lo_q <= s6_mid_q) && (s6_mid_q <= s6_hi_q))
    else $error("sorted tones out of order");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !rdy[1] |=> vld_q[0] && $stable(s1_num_q) && $stable(s1_tonic_q))
    else $error("first stage beat lost during stall");
`endif

endmodule
